[hdl/fvn_pkg.sv]
// Shared constants for the fractal value noise height generator.
`timescale 1ns / 1ps
package fvn_pkg;

    // Corner hash multipliers
    localparam logic [31:0] HX_MUL   = 32'd374761393;
    localparam logic [31:0] HZ_MUL   = 32'd668265263;
    localparam logic [31:0] HMIX_MUL = 32'd1274126177;

    // Corner value width (top half of the hash)
    localparam int VAL_W = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd1;

    localparam int SEED_W  = 32;
    localparam int SCALE_W = 16;
    localparam int CFG_W   = 32;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    // Result widths
    localparam int RAW_W    = 16;
    localparam int SCALED_W = 24;
    localparam int OUT_W    = 40;

    // Stages inside one octave cell
    localparam int CELL_STAGES = 7;

endpackage

[hdl/fvn_cell.sv]
// One octave cell: hashes, smooths and blends one octave, adds it to the running sum.
`timescale 1ns / 1ps
module fvn_cell #(
    parameter int FRAC_BITS = 16,
    parameter int OCTAVES   = 4,
    parameter int OCT       = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [31:0]             seed,
    input  logic                    in_valid,
    input  logic [FRAC_BITS:0]      in_x,
    input  logic [FRAC_BITS:0]      in_z,
    input  logic [15+OCTAVES:0]     in_acc,
    output logic                    out_valid,
    output logic [FRAC_BITS:0]      out_x,
    output logic [FRAC_BITS:0]      out_z,
    output logic [15+OCTAVES:0]     out_acc
);

    localparam int F   = FRAC_BITS;
    localparam int SH  = 2 + OCT;
    localparam int PW  = F + 1;
    localparam int SW  = PW + SH;
    localparam int CW  = SW - F;
    localparam int AW  = 16 + OCTAVES;
    localparam int W2  = 2 * F;
    localparam int TW  = F + 2;
    localparam int SMW = F + TW;
    localparam int PRW = fvn_pkg::VAL_W + F + 1;
    localparam int ST  = fvn_pkg::CELL_STAGES;
    localparam logic [F:0]    ONE   = (F+1)'(1) << F;
    localparam logic [TW-1:0] THREE = TW'(3) << F;

    // position / sum carried alongside the math
    logic          vld_reg  [ST-1];
    logic [PW-1:0] px_reg   [ST-1];
    logic [PW-1:0] pz_reg   [ST-1];
    logic [AW-1:0] acc_reg  [ST-1];

    // stage 1
    logic [SW-1:0] sx, sz;
    logic [CW-1:0] cx, cz;
    logic [F-1:0]  fx, fz;
    logic [31:0]   ax_reg, az_reg;
    logic [F-1:0]  fx_reg, fz_reg;
    logic [W2-1:0] sqx_reg, sqz_reg;

    // stage 2
    logic [31:0]    nsum [4];
    logic [31:0]    mix_next [4];
    logic [31:0]    mix_reg [4];
    logic [TW-1:0]  tx, tz;
    logic [SMW-1:0] swx_reg, swz_reg;

    // stage 3
    logic [31:0]    hprod [4];
    logic [15:0]    hv_reg [4];
    logic [F:0]     wx_reg, wz3_reg;

    // stage 4
    logic [PRW-1:0] pa0_reg, pb0_reg, pa1_reg, pb1_reg;
    logic [F:0]     wz4_reg;

    // stage 5
    logic [PRW:0]   sum0, sum1;
    logic [15:0]    r0_reg, r1_reg;
    logic [F:0]     wz5_reg;

    // stage 6
    logic [PRW-1:0] qa_reg, qb_reg;

    // stage 7
    logic [PRW:0]   qsum;
    logic [15:0]    nval;
    logic [AW-1:0]  acc_out_reg;
    logic           vld_out_reg;
    logic [PW-1:0]  px_out_reg, pz_out_reg;

    always_comb
    begin
        sx = {in_x, {SH{1'b0}}};
        sz = {in_z, {SH{1'b0}}};
        cx = sx[SW-1:F];
        cz = sz[SW-1:F];
        fx = sx[F-1:0];
        fz = sz[F-1:0];

        // corner order: 00, 10, 01, 11
        nsum[0] = ax_reg + az_reg;
        nsum[1] = ax_reg + fvn_pkg::HX_MUL + az_reg;
        nsum[2] = ax_reg + az_reg + fvn_pkg::HZ_MUL;
        nsum[3] = ax_reg + fvn_pkg::HX_MUL + az_reg + fvn_pkg::HZ_MUL;
        for (int i = 0; i < 4; i++)
        begin
            mix_next[i] = (nsum[i] ^ seed) ^ ((nsum[i] ^ seed) >> 13);
            hprod[i]    = mix_reg[i] * fvn_pkg::HMIX_MUL;
        end

        tx = THREE - {1'b0, fx_reg, 1'b0};
        tz = THREE - {1'b0, fz_reg, 1'b0};

        sum0 = {1'b0, pa0_reg} + {1'b0, pb0_reg};
        sum1 = {1'b0, pa1_reg} + {1'b0, pb1_reg};
        qsum = {1'b0, qa_reg} + {1'b0, qb_reg};
        nval = qsum[F+15:F];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ST-1; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < ST-1; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            vld_out_reg <= vld_reg[ST-2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0]  <= in_x;
            pz_reg[0]  <= in_z;
            acc_reg[0] <= in_acc;
            for (int i = 1; i < ST-1; i++)
            begin
                px_reg[i]  <= px_reg[i-1];
                pz_reg[i]  <= pz_reg[i-1];
                acc_reg[i] <= acc_reg[i-1];
            end

            // stage 1: cell hash products, fraction squares
            ax_reg  <= 32'(cx) * fvn_pkg::HX_MUL;
            az_reg  <= 32'(cz) * fvn_pkg::HZ_MUL;
            fx_reg  <= fx;
            fz_reg  <= fz;
            sqx_reg <= W2'(fx) * W2'(fx);
            sqz_reg <= W2'(fz) * W2'(fz);

            // stage 2: corner mix, smoothstep product
            for (int i = 0; i < 4; i++)
            begin
                mix_reg[i] <= mix_next[i];
            end
            swx_reg <= SMW'(sqx_reg[W2-1:F]) * SMW'(tx);
            swz_reg <= SMW'(sqz_reg[W2-1:F]) * SMW'(tz);

            // stage 3: final hash multiply
            for (int i = 0; i < 4; i++)
            begin
                hv_reg[i] <= hprod[i][31:16];
            end
            wx_reg  <= swx_reg[2*F:F];
            wz3_reg <= swz_reg[2*F:F];

            // stage 4: x blend products
            pa0_reg <= PRW'(hv_reg[0]) * PRW'(ONE - wx_reg);
            pb0_reg <= PRW'(hv_reg[1]) * PRW'(wx_reg);
            pa1_reg <= PRW'(hv_reg[2]) * PRW'(ONE - wx_reg);
            pb1_reg <= PRW'(hv_reg[3]) * PRW'(wx_reg);
            wz4_reg <= wz3_reg;

            // stage 5: x blend sums
            r0_reg  <= sum0[F+15:F];
            r1_reg  <= sum1[F+15:F];
            wz5_reg <= wz4_reg;

            // stage 6: z blend products
            qa_reg <= PRW'(r0_reg) * PRW'(ONE - wz5_reg);
            qb_reg <= PRW'(r1_reg) * PRW'(wz5_reg);

            // stage 7: weighted accumulate
            acc_out_reg <= acc_reg[ST-2] + (AW'(nval) << (OCTAVES - 1 - OCT));
            px_out_reg  <= px_reg[ST-2];
            pz_out_reg  <= pz_reg[ST-2];
        end
    end

    assign out_valid = vld_out_reg;
    assign out_x     = px_out_reg;
    assign out_z     = pz_out_reg;
    assign out_acc   = acc_out_reg;

endmodule

[hdl/fvn_output.sv]
// Height scaling stage, output register and skid buffer.
`timescale 1ns / 1ps
module fvn_output (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [fvn_pkg::RAW_W-1:0]           in_raw,
    input  logic [fvn_pkg::SCALE_W-1:0]         height_scale,
    output logic                                en,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fvn_pkg::OUT_W-1:0]           m_tdata
);

    localparam int PW = fvn_pkg::RAW_W + fvn_pkg::SCALE_W;

    logic                       sv_reg;
    logic [fvn_pkg::RAW_W-1:0]  sraw_reg;
    logic [PW-1:0]              sprod_reg;
    logic [fvn_pkg::OUT_W-1:0]  sdata;

    logic                       out_valid_reg;
    logic [fvn_pkg::OUT_W-1:0]  out_data_reg;
    logic                       skid_valid_reg;
    logic [fvn_pkg::OUT_W-1:0]  skid_data_reg;
    logic                       take;

    assign en    = !skid_valid_reg;
    assign take  = out_valid_reg && m_tready;
    // product never exceeds 24 bits after the shift, so no clamp is needed
    assign sdata = {sprod_reg[PW-1:8], sraw_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sraw_reg  <= in_raw;
            sprod_reg <= PW'(in_raw) * PW'(height_scale);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (sv_reg)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (sv_reg)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_reg <= sdata;
            end
            else
            begin
                skid_data_reg <= sdata;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_tready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid data lost during stall");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !skid_valid_reg && sv_reg && out_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("scaled result dropped while output stalled");

endmodule

[hdl/fractal_value_noise_height.sv]
// Top level: config registers, chain of octave cells, scaling and output.
//
// Input channel s_*: one sample position (x_pos, z_pos) per transfer.
// Output channel m_*: one height (raw_height, scaled_height) per input.
// Config port: cfg_wr_en / cfg_index / cfg_wdata; index 0 = seed,
// index 1 = height_scale; other indexes are ignored. Write only when idle.
// Path: octave cells, a scaling register, then the output register.
// Throughput: one position per cycle while the skid buffer is empty;
// each octave cell is a 7-stage pipeline and hands position and
// running sum to the next cell.
// Reset: seed 0, height_scale 1.0 (256), pipeline and output empty.
// Stall: a two-entry output (register plus skid) absorbs one stalled
// result; the whole chain then holds and s_tready drops until the skid
// empties. Input is still taken while a result waits in the output.
`timescale 1ns / 1ps
module fractal_value_noise_height #(
    parameter int FRAC_BITS = 16,
    parameter int OCTAVES   = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_pos, z_pos, zero pad
    input  logic [((2*(FRAC_BITS+1)+7)/8)*8-1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // raw_height, scaled_height
    output logic [fvn_pkg::OUT_W-1:0]           m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fvn_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int PW = FRAC_BITS + 1;
    localparam int AW = 16 + OCTAVES;

    logic [fvn_pkg::SEED_W-1:0]  seed_reg;
    logic [fvn_pkg::SCALE_W-1:0] scale_reg;
    logic                        en;

    logic          cv  [OCTAVES+1];
    logic [PW-1:0] cx  [OCTAVES+1];
    logic [PW-1:0] cz  [OCTAVES+1];
    logic [AW-1:0] ca  [OCTAVES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            scale_reg <= fvn_pkg::SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fvn_pkg::CFG_SEED:
                begin
                    seed_reg <= cfg_wdata[fvn_pkg::SEED_W-1:0];
                end
                fvn_pkg::CFG_HEIGHT_SCALE:
                begin
                    scale_reg <= cfg_wdata[fvn_pkg::SCALE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = en;
    assign cv[0]    = s_tvalid && en;
    assign cx[0]    = s_tdata[PW-1:0];
    assign cz[0]    = s_tdata[2*PW-1:PW];
    assign ca[0]    = '0;

    for (genvar o = 0; o < OCTAVES; o++)
    begin : g_oct
        fvn_cell #(
            .FRAC_BITS (FRAC_BITS),
            .OCTAVES   (OCTAVES),
            .OCT       (o)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .seed      (seed_reg),
            .in_valid  (cv[o]),
            .in_x      (cx[o]),
            .in_z      (cz[o]),
            .in_acc    (ca[o]),
            .out_valid (cv[o+1]),
            .out_x     (cx[o+1]),
            .out_z     (cz[o+1]),
            .out_acc   (ca[o+1])
        );
    end

    fvn_output u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cv[OCTAVES]),
        .in_raw       (ca[OCTAVES][AW-1:OCTAVES]),
        .height_scale (scale_reg),
        .en           (en),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

[tb/sv/fractal_value_noise_height_chk.sv]
// Checker for the fractal value noise height generator: predicts and compares each result.
`timescale 1ns / 1ps
module fractal_value_noise_height_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [39:0]                     s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fvn_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fvn_pkg::CFG_W-1:0]       cfg_wdata,
    output int                              fail_count,
    output int                              pending
);

    typedef struct packed {
        logic [fvn_pkg::SCALED_W-1:0] scaled_height;
        logic [fvn_pkg::RAW_W-1:0]    raw_height;
    } height_t;

    logic [fvn_pkg::SEED_W-1:0]  cur_seed;
    logic [fvn_pkg::SCALE_W-1:0] cur_scale;
    height_t                     height_q[$];

    function automatic logic [15:0] corner_hash(logic [31:0] cx, logic [31:0] cz);
        logic [31:0] n;
        n = cx * fvn_pkg::HX_MUL + cz * fvn_pkg::HZ_MUL;
        n = n ^ cur_seed;
        n = (n ^ (n >> 13)) * fvn_pkg::HMIX_MUL;
        n = n ^ (n >> 16);
        return n[31:16];
    endfunction

    function automatic logic [63:0] ease(logic [63:0] f);
        logic [63:0] sq;
        sq = (f * f) >> 16;
        return (sq * (64'd3 * 64'd65536 - 64'd2 * f)) >> 16;
    endfunction

    function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        return (a * (64'd65536 - w) + b * w) >> 16;
    endfunction

    function automatic height_t terrain_height(logic [16:0] px, logic [16:0] pz);
        logic [63:0] sx, sz, wx, wz, r0, r1, acc, scaled;
        logic [31:0] cx, cz;
        height_t h;
        acc = 0;
        for (int o = 0; o < 4; o++)
        begin
            sx = 64'(px) << (2 + o);
            sz = 64'(pz) << (2 + o);
            cx = sx[47:16];
            cz = sz[47:16];
            wx = ease(64'(sx[15:0]));
            wz = ease(64'(sz[15:0]));
            r0 = mix(64'(corner_hash(cx, cz)), 64'(corner_hash(cx + 1, cz)), wx);
            r1 = mix(64'(corner_hash(cx, cz + 1)), 64'(corner_hash(cx + 1, cz + 1)), wx);
            acc += mix(r0, r1, wz) << (3 - o);
        end
        h.raw_height = acc[19:4];
        scaled = (64'(h.raw_height) * 64'(cur_scale)) >> 8;
        h.scaled_height = (scaled > 64'hFFFFFF) ? 24'hFFFFFF : scaled[23:0];
        return h;
    endfunction

    assign pending = height_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        height_t want, got;
        int errs;
        if (!rst_n)
        begin
            cur_seed   <= '0;
            cur_scale  <= fvn_pkg::SCALE_RESET;
            fail_count <= 0;
            height_q.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_wr_en)
            begin
                if (cfg_index == fvn_pkg::CFG_SEED)
                    cur_seed <= cfg_wdata;
                else if (cfg_index == fvn_pkg::CFG_HEIGHT_SCALE)
                    cur_scale <= cfg_wdata[fvn_pkg::SCALE_W-1:0];
            end
            if (s_tvalid && s_tready)
                height_q.insert(height_q.size(),
                                terrain_height(s_tdata[16:0], s_tdata[33:17]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (height_q.size() == 0)
                begin
                    $display("%0t: unexpected result raw=%0d scaled=%0d", $time,
                             got.raw_height, got.scaled_height);
                    errs++;
                end
                else
                begin
                    want = height_q.pop_front();
                    if (got.raw_height !== want.raw_height)
                    begin
                        $display("%0t: raw_height expected %0d actual %0d", $time,
                                 want.raw_height, got.raw_height);
                        errs++;
                    end
                    if (got.scaled_height !== want.scaled_height)
                    begin
                        $display("%0t: scaled_height expected %0d actual %0d", $time,
                                 want.scaled_height, got.scaled_height);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

[tb/sv/fractal_value_noise_height_tb.sv]
// Testbench top for the fractal value noise height generator: stimulus and verdict.
`timescale 1ns / 1ps
module fractal_value_noise_height_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic                               clk = 0;
    logic                               rst_n = 0;
    logic                               s_tvalid = 0;
    logic                               s_tready;
    logic [39:0]                        s_tdata = '0;
    logic                               m_tvalid;
    logic                               m_tready = 0;
    logic [fvn_pkg::OUT_W-1:0]          m_tdata;
    logic                               cfg_wr_en = 0;
    logic [fvn_pkg::CFG_IDX_W-1:0]      cfg_index = fvn_pkg::CFG_SEED;
    logic [fvn_pkg::CFG_W-1:0]          cfg_wdata = '0;
    int                                 fail_count;
    int                                 pending;
    int                                 cycles = 0;
    bit                                 quiet = 0;
    bit                                 hold_req = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    fractal_value_noise_height uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    fractal_value_noise_height_chk chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fractal_value_noise_height_tb: done, errors");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 0;
                for (n = 0; n < 300; n++)
                    @(posedge clk);
                hold_req = 0;
                m_tready <= 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge clk);
                m_tready <= 1;
            end
            else
                m_tready <= 1;
        end
    end

    task automatic send_pos(logic [16:0] x, logic [16:0] z);
        int gap;
        s_tdata  <= {6'd0, z, x};
        s_tvalid <= 1;
        do
            @(posedge clk);
        while (!s_tready);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [fvn_pkg::CFG_IDX_W-1:0] idx,
                             logic [fvn_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 0;
    endtask

    // Let every result drain before touching the registers
    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    logic [31:0] seeds[6]  = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A, 32'h0,
                               32'h8000_0001};
    logic [15:0] scales[6] = '{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 16'd256};
    logic [16:0] edges[7]  = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536,
                               17'd65537, 17'h1FFFF};

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes, exactly 1.0 and positions past 1.0
        for (int i = 0; i < 7; i++)
            for (int j = 0; j < 3; j++)
                send_pos(edges[i], edges[(i + 2 * j) % 7]);
        drain();
        // ignored indexes must not disturb anything
        write_reg(2'd2, 32'hDEAD_BEEF);
        write_reg(2'd3, 32'h0000_0100);

        for (int p = 0; p < 6; p++)
        begin
            write_reg(fvn_pkg::CFG_SEED, (p == 4) ? $urandom() : seeds[p]);
            write_reg(fvn_pkg::CFG_HEIGHT_SCALE,
                      {16'd0, (p == 3) ? 16'($urandom()) : scales[p]});
            if (p == 1)
                hold_req = 1;
            if (p == 5)
                quiet = 1;
            for (int k = 0; k < 315; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_pos(17'($urandom()), 17'($urandom()));
                else
                    send_pos(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
            end
            drain();
        end

        if (fail_count == 0)
            $display("fractal_value_noise_height_tb: done, clean");
        else
            $display("fractal_value_noise_height_tb: done, errors");
        $finish;
    end

endmodule
